FILE: hw/rtl/eiwa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eiwa_pkg;

    // fixed field widths
    localparam int TICK_W    = 32;
    localparam int CFG_W     = 5;
    localparam int SAMPLES_W = 5;

    // serial divider: one quotient bit per cycle over the 32-bit mean
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;

    // reset value of the ready threshold
    localparam logic [CFG_W-1:0] MIN_READY_RESET = 5'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUM_END,
        ST_DIV,
        ST_FINISH
    } seq_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/event_interval_window_average.sv
`timescale 1ns / 1ps
`default_nettype none

// Moving average of the time between events.
// Input channel (in_valid/in_ready) carries one event: connect_time and tick_now.
// Output channel (out_valid/out_ready) returns one result per event: the floored
// mean of the stored intervals, the number of stored intervals and a ready flag.
// cfg_we/cfg_wdata write the ready threshold (min_samples_for_ready); write it
// only while no event is in flight.
// An event that stores an interval writes it into the ring, then sums the
// filled slots by reading the ring memory one slot a cycle, then runs a
// bit-serial divider (one quotient bit a cycle). The result is registered
// into the output register from the finish state once that register is free.
// An event that stores nothing (link down, first event after a restart) goes
// straight from idle to the finish state.
// in_ready is high only while the sequencer is idle; one event is worked on at
// a time, so the next event can be taken only after the previous one has left
// the finish state.
// A finished result waits in the output register, so the next event can be
// taken while the receiver stalls; a second result waits until the first one
// has been transferred.
// Reset clears the chain, the fill count, the mean and sets the threshold to 4.
// The ring memory is not cleared: only filled slots are ever summed.
module event_interval_window_average #(
    parameter int RING_SLOTS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [eiwa_pkg::TICK_W-1:0]    connect_time,
    input  wire logic [eiwa_pkg::TICK_W-1:0]    tick_now,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [eiwa_pkg::TICK_W-1:0]    average_interval,
    output logic      [eiwa_pkg::SAMPLES_W-1:0] samples_stored,
    output logic                                average_ready,
    input  wire logic                           cfg_we,
    input  wire logic [eiwa_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int TW     = eiwa_pkg::TICK_W;
    localparam int IDX_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int FILL_W = $clog2(RING_SLOTS + 1);
    localparam int CMP_W  = (FILL_W > eiwa_pkg::CFG_W) ? FILL_W : eiwa_pkg::CFG_W;
    localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(RING_SLOTS - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(RING_SLOTS);

    eiwa_pkg::seq_state_t state_reg, state_next;

    logic [eiwa_pkg::CFG_W-1:0]     min_ready_reg, min_ready_next;
    logic [TW-1:0]                  last_connect_reg, last_connect_next;
    logic [TW-1:0]                  last_tick_reg, last_tick_next;
    logic [IDX_W-1:0]               write_slot_reg, write_slot_next;
    logic [FILL_W-1:0]              fill_reg, fill_next;
    logic [TW-1:0]                  mean_reg, mean_next;
    logic [IDX_W-1:0]               rd_cnt_reg, rd_cnt_next;
    logic                           rd_vld_reg, rd_vld_next;
    logic [FILL_W-1:0]              rem_reg, rem_next;
    logic [TW-1:0]                  quo_reg, quo_next;
    logic [eiwa_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                           out_valid_reg, out_valid_next;
    logic [TW-1:0]                  out_avg_reg, out_avg_next;
    logic [eiwa_pkg::SAMPLES_W-1:0] out_cnt_reg, out_cnt_next;
    logic                           out_rdy_reg, out_rdy_next;

    // decoded control
    logic accept;
    logic restart;
    logic [TW-1:0] prev_tick;
    logic do_store;
    logic sum_last;
    logic div_last;
    logic finish_go;
    logic in_idle;
    logic in_sum;
    logic in_div;
    logic in_finish;

    // datapath helpers
    logic [TW-1:0]          interval;
    logic [FILL_W+TW-1:0]   acc_sum;
    logic [FILL_W:0]        trial;
    logic [FILL_W:0]        trial_diff;
    logic                   trial_ge;
    logic [CMP_W-1:0]       fill_ext;
    logic [CMP_W-1:0]       min_ext;
    logic [TW-1:0]          ram_rdata;

    // ring memory
    eiwa_ram #(
        .WIDTH (TW),
        .DEPTH (RING_SLOTS),
        .ADDR_W(IDX_W)
    ) u_ring (
        .clk  (clk),
        .we   (do_store),
        .waddr(write_slot_reg),
        .wdata(interval),
        .raddr(rd_cnt_reg),
        .rdata(ram_rdata)
    );

    // event decode
    assign accept    = in_valid && in_ready;
    assign restart   = connect_time < last_connect_reg;
    assign prev_tick = restart ? '0 : last_tick_reg;
    assign interval  = tick_now - prev_tick;
    assign do_store  = accept && (connect_time != '0) && (prev_tick != '0);
    assign sum_last  = (FILL_W'(rd_cnt_reg) == (fill_reg - FILL_W'(1)));
    assign div_last  = (div_cnt_reg == eiwa_pkg::DIV_CNT_W'(eiwa_pkg::DIV_STEPS - 1));
    assign finish_go = !out_valid_reg || out_ready;

    // shared arithmetic: accumulate and restoring divide step
    assign acc_sum    = {rem_reg, quo_reg} + (FILL_W + TW)'(ram_rdata);
    assign trial      = {rem_reg, quo_reg[TW-1]};
    assign trial_diff = trial - {1'b0, fill_reg};
    assign trial_ge   = (trial >= {1'b0, fill_reg});

    // ready threshold compare at a common width
    assign fill_ext = CMP_W'(fill_reg);
    assign min_ext  = CMP_W'(min_ready_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            eiwa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = do_store ? eiwa_pkg::ST_SUM : eiwa_pkg::ST_FINISH;
                end
            end
            eiwa_pkg::ST_SUM:
            begin
                if (sum_last)
                begin
                    state_next = eiwa_pkg::ST_SUM_END;
                end
            end
            eiwa_pkg::ST_SUM_END:
            begin
                state_next = eiwa_pkg::ST_DIV;
            end
            eiwa_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = eiwa_pkg::ST_FINISH;
                end
            end
            eiwa_pkg::ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = eiwa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = eiwa_pkg::ST_IDLE;
            end
        endcase
    end

    // state decode
    always_comb
    begin
        in_idle   = 1'b0;
        in_sum    = 1'b0;
        in_div    = 1'b0;
        in_finish = 1'b0;
        case (state_reg)
            eiwa_pkg::ST_IDLE:    in_idle   = 1'b1;
            eiwa_pkg::ST_SUM:     in_sum    = 1'b1;
            eiwa_pkg::ST_SUM_END: in_sum    = 1'b0;
            eiwa_pkg::ST_DIV:     in_div    = 1'b1;
            eiwa_pkg::ST_FINISH:  in_finish = 1'b1;
            default:              in_idle   = 1'b0;
        endcase
    end

    assign in_ready = in_idle;

    // datapath next values
    always_comb
    begin
        min_ready_next    = min_ready_reg;
        last_connect_next = last_connect_reg;
        last_tick_next    = last_tick_reg;
        write_slot_next   = write_slot_reg;
        fill_next         = fill_reg;
        mean_next         = mean_reg;
        rd_cnt_next       = rd_cnt_reg;
        rd_vld_next       = in_sum;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        div_cnt_next      = div_cnt_reg;
        out_valid_next    = out_valid_reg;
        out_avg_next      = out_avg_reg;
        out_cnt_next      = out_cnt_reg;
        out_rdy_next      = out_rdy_reg;

        if (cfg_we)
        begin
            min_ready_next = cfg_wdata;
        end

        // event update: restart, link down, first event or stored interval
        if (accept)
        begin
            if (restart)
            begin
                last_tick_next = '0;
            end
            if (connect_time != '0)
            begin
                last_connect_next = connect_time;
                last_tick_next    = tick_now;
            end
            if (do_store)
            begin
                write_slot_next = (write_slot_reg == LAST_SLOT) ? '0
                                : write_slot_reg + IDX_W'(1);
                if (fill_reg < FULL_FILL)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            rd_cnt_next  = '0;
            rem_next     = '0;
            quo_next     = '0;
            div_cnt_next = '0;
        end

        // walk the filled slots
        if (in_sum)
        begin
            rd_cnt_next = rd_cnt_reg + IDX_W'(1);
        end
        if (rd_vld_reg)
        begin
            {rem_next, quo_next} = acc_sum;
        end

        // one quotient bit per cycle
        if (in_div)
        begin
            rem_next     = trial_ge ? trial_diff[FILL_W-1:0] : trial[FILL_W-1:0];
            quo_next     = {quo_reg[TW-2:0], trial_ge};
            div_cnt_next = div_cnt_reg + eiwa_pkg::DIV_CNT_W'(1);
            if (div_last)
            begin
                mean_next = {quo_reg[TW-2:0], trial_ge};
            end
        end

        // output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_finish && finish_go)
        begin
            out_valid_next = 1'b1;
            out_avg_next   = mean_reg;
            out_cnt_next   = fill_ext[eiwa_pkg::SAMPLES_W-1:0];
            out_rdy_next   = (fill_ext >= min_ext);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= eiwa_pkg::ST_IDLE;
            min_ready_reg    <= eiwa_pkg::MIN_READY_RESET;
            last_connect_reg <= '0;
            last_tick_reg    <= '0;
            write_slot_reg   <= '0;
            fill_reg         <= '0;
            mean_reg         <= '0;
            rd_vld_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            min_ready_reg    <= min_ready_next;
            last_connect_reg <= last_connect_next;
            last_tick_reg    <= last_tick_next;
            write_slot_reg   <= write_slot_next;
            fill_reg         <= fill_next;
            mean_reg         <= mean_next;
            rd_vld_reg       <= rd_vld_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        rd_cnt_reg  <= rd_cnt_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        div_cnt_reg <= div_cnt_next;
        out_avg_reg <= out_avg_next;
        out_cnt_reg <= out_cnt_next;
        out_rdy_reg <= out_rdy_next;
    end

    assign out_valid        = out_valid_reg;
    assign average_interval = out_avg_reg;
    assign samples_stored   = out_cnt_reg;
    assign average_ready    = out_rdy_reg;

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_FILL)
        else $error("fill count above ring size");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        write_slot_reg <= LAST_SLOT)
        else $error("write slot outside ring");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_div |-> (rem_reg < fill_reg))
        else $error("divider remainder not below divisor");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("event taken while previous one in flight");

endmodule

`default_nettype wire

FILE: hw/rtl/eiwa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module eiwa_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
